>>> rtl/pfa_pkg.sv
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared codes and types for the page frame allocator.
// ----------------------------------------------------------------------------
package pfa_pkg;

	localparam int TOT_W   = 21;
	localparam int COUNT_W = 16;
	localparam int PAGE_W  = 15;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_INC   = 2'd2,
		OP_DEC   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_OOM      = 3'd1,
		ST_BAD_FREE = 3'd2,
		ST_RANGE    = 3'd3,
		ST_OVERFLOW = 3'd4
	} status_t;

	typedef enum logic {
		REG_TOTAL      = 1'b0,
		REG_FIRST_FREE = 1'b1
	} reg_idx_t;

	// rebuild bounds: total, first free, low end, high start
	typedef struct packed {
		logic [TOT_W-1:0] total;
		logic [TOT_W-1:0] first;
		logic [TOT_W-1:0] low_end;
		logic [TOT_W-1:0] hi_start;
	} region_t;

endpackage

>>> rtl/pfa_page_mem.sv
// ----------------------------------------------------------------------------
// pfa_page_mem
// Per-page entry store, one write and one registered read port.
// ----------------------------------------------------------------------------
module pfa_page_mem #(
	parameter int AW = 15,
	parameter int EW = 33
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [EW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [EW-1:0] rdata
);

	logic [EW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/pfa_rebuild.sv
// ----------------------------------------------------------------------------
// pfa_rebuild
// Sweep that writes the rebuilt free chain and counts into every page entry.
// ----------------------------------------------------------------------------
module pfa_rebuild import pfa_pkg::*; #(
	parameter int NUM_PAGES = 32768,
	parameter int AW = 15,
	parameter int EW = 33
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  region_t       region,
	output logic          busy,
	output logic [AW-1:0] addr,
	output logic [EW-1:0] wdata
);

	localparam logic [AW-1:0] LAST_IDX = AW'(NUM_PAGES - 1);

	logic [AW-1:0]    idx_q;
	logic             busy_q;
	logic [TOT_W-1:0] i_w;
	logic             in_low;
	logic             in_high;
	logic             last;
	logic [TOT_W-1:0] nxt;
	logic [COUNT_W-1:0] cnt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			busy_q <= 1'b1;
		end else if (start) begin
			idx_q  <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			if (idx_q == LAST_IDX) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_comb begin
		i_w     = TOT_W'(idx_q);
		in_low  = (i_w >= region.first) && (i_w < region.low_end);
		in_high = (i_w >= region.hi_start) && (i_w < region.total);
		cnt     = (i_w < region.first) ? COUNT_W'(1) : '0;
		last    = 1'b1;
		nxt     = '0;
		if (in_low) begin
			if (i_w != region.first) begin
				last = 1'b0;
				nxt  = i_w - 1'b1;
			end else if (region.hi_start < region.total) begin
				last = 1'b0;
				nxt  = region.total - 1'b1;
			end
		end else if (in_high && (i_w != region.hi_start)) begin
			last = 1'b0;
			nxt  = i_w - 1'b1;
		end
	end

	assign busy  = busy_q;
	assign addr  = idx_q;
	assign wdata = {in_low | in_high, last, nxt[AW-1:0], cnt};

endmodule

>>> rtl/page_frame_allocator_refcount.sv
// ----------------------------------------------------------------------------
// page_frame_allocator_refcount
// Page frame allocator with a LIFO free list and per-page reference counts.
// ----------------------------------------------------------------------------
// The page entry is read when an item is accepted, then modified and written back
// as the result is registered; s_tready stays low until that result is loaded.
// Reset and every write to total_pages or first_free_page start a rebuild pass
// over every page memory entry; s_tready stays low during it.
// ----------------------------------------------------------------------------
module page_frame_allocator_refcount import pfa_pkg::*; #(
	parameter int NUM_PAGES  = 32768,
	parameter int LOW_REGION = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // op[1:0], page[16:2]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // page_out[14:0], count_after[30:15], freed[31],
	                               // status[34:32]
);

	localparam int AW = $clog2(NUM_PAGES);
	localparam int EW = AW + 18;
	localparam logic [TOT_W-1:0] NP_W = TOT_W'(NUM_PAGES);
	localparam logic [TOT_W-1:0] LR_W = TOT_W'(LOW_REGION);

	logic [15:0]   total_q;
	logic [10:0]   first_q;
	region_t       region;
	logic [TOT_W-1:0] ff_w;
	logic [AW-1:0] rb_head;
	logic          rb_empty;

	logic          init_busy;
	logic [AW-1:0] init_addr;
	logic [EW-1:0] init_wdata;

	logic [AW-1:0] head_q;
	logic          empty_q;
	logic          busy_q;
	op_t           op_s1;
	logic [PAGE_W-1:0] page_s1;
	logic [AW-1:0] addr_s1;
	logic          bad_s1;

	op_t           in_op;
	logic [PAGE_W-1:0] in_page;
	logic [AW-1:0] in_addr;
	logic          accept;
	logic [AW-1:0] rd_addr;
	logic [EW-1:0] rd_entry;

	logic [COUNT_W-1:0] r_count;
	logic [AW-1:0] r_next;
	logic          r_last;
	logic          r_listed;
	logic [PAGE_W-1:0] addr_page;

	logic          wr_en;
	logic [EW-1:0] wr_entry;
	logic [AW-1:0] head_d;
	logic          empty_d;
	logic [PAGE_W-1:0] res_page;
	logic [COUNT_W-1:0] res_cnt;
	logic          res_freed;
	status_t       res_status;
	logic [COUNT_W-1:0] dec_cnt;

	logic          load_out;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [EW-1:0] mem_wdata;

	logic          m_tvalid_q;
	logic [PAGE_W-1:0] out_page_q;
	logic [COUNT_W-1:0] out_cnt_q;
	logic          out_freed_q;
	status_t       out_status_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= 16'd32768;
			first_q <= 11'd256;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_TOTAL:      total_q <= cfg_wdata;
				REG_FIRST_FREE: first_q <= cfg_wdata[10:0];
				default:        ;
			endcase
		end
	end

	always_comb begin
		region.total    = (TOT_W'(total_q) > NP_W) ? NP_W : TOT_W'(total_q);
		ff_w            = TOT_W'(first_q);
		region.first    = (ff_w > region.total) ? region.total : ff_w;
		region.low_end  = (LR_W > region.total) ? region.total : LR_W;
		region.hi_start = (region.first > LR_W) ? region.first : LR_W;
		rb_empty = 1'b0;
		if (region.first < region.low_end) begin
			rb_head = AW'(region.low_end - 1'b1);
		end else if (region.hi_start < region.total) begin
			rb_head = AW'(region.total - 1'b1);
		end else begin
			rb_head  = '0;
			rb_empty = 1'b1;
		end
	end

	pfa_rebuild #(
		.NUM_PAGES(NUM_PAGES),
		.AW(AW),
		.EW(EW)
	) u_rebuild (
		.clk(clk),
		.arst_n(arst_n),
		.start(cfg_we),
		.region(region),
		.busy(init_busy),
		.addr(init_addr),
		.wdata(init_wdata)
	);

	// input side
	assign in_op   = op_t'(s_tdata[1:0]);
	assign in_page = s_tdata[16:2];
	assign s_tready = !init_busy && !busy_q;
	assign accept  = s_tvalid && s_tready;

	generate
		if (AW > PAGE_W) begin : g_wide
			assign in_addr   = {{(AW-PAGE_W){1'b0}}, in_page};
			assign addr_page = addr_s1[PAGE_W-1:0];
		end else if (AW == PAGE_W) begin : g_same
			assign in_addr   = in_page;
			assign addr_page = addr_s1;
		end else begin : g_narrow
			assign in_addr   = in_page[AW-1:0];
			assign addr_page = {{(PAGE_W-AW){1'b0}}, addr_s1};
		end
	endgenerate

	assign rd_addr = (in_op == OP_ALLOC) ? head_q : in_addr;

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= in_op;
			page_s1 <= in_page;
			addr_s1 <= rd_addr;
			bad_s1  <= TOT_W'(in_page) >= region.total;
		end
	end

	pfa_page_mem #(
		.AW(AW),
		.EW(EW)
	) u_mem (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re(accept),
		.raddr(rd_addr),
		.rdata(rd_entry)
	);

	// modify
	assign r_count  = rd_entry[COUNT_W-1:0];
	assign r_next   = rd_entry[AW+15:16];
	assign r_last   = rd_entry[AW+16];
	assign r_listed = rd_entry[AW+17];
	assign dec_cnt  = r_count - 1'b1;

	always_comb begin
		wr_en      = 1'b0;
		wr_entry   = rd_entry;
		head_d     = head_q;
		empty_d    = empty_q;
		res_page   = page_s1;
		res_cnt    = r_count;
		res_freed  = 1'b0;
		res_status = ST_OK;
		if (op_s1 == OP_ALLOC) begin
			if (empty_q) begin
				res_page   = '0;
				res_cnt    = '0;
				res_status = ST_OOM;
			end else begin
				res_page = addr_page;
				wr_en    = 1'b1;
				wr_entry = {1'b0, 1'b1, {AW{1'b0}}, r_count};
				if (r_last) begin
					empty_d = 1'b1;
				end else begin
					head_d = r_next;
				end
			end
		end else if (bad_s1) begin
			res_cnt    = '0;
			res_status = ST_RANGE;
		end else begin
			case (op_s1)
				OP_FREE: begin
					if (r_count != '0 || r_listed) begin
						res_status = ST_BAD_FREE;
					end else begin
						wr_en     = 1'b1;
						wr_entry  = {1'b1, empty_q, head_q, r_count};
						head_d    = addr_s1;
						empty_d   = 1'b0;
						res_freed = 1'b1;
					end
				end
				OP_INC: begin
					if (r_count == COUNT_MAX) begin
						res_status = ST_OVERFLOW;
					end else begin
						res_cnt  = r_count + 1'b1;
						wr_en    = 1'b1;
						wr_entry = {r_listed, r_last, r_next, res_cnt};
					end
				end
				OP_DEC: begin
					if (r_count == '0) begin
						res_status = ST_BAD_FREE;
					end else begin
						res_cnt  = dec_cnt;
						wr_en    = 1'b1;
						wr_entry = {r_listed, r_last, r_next, dec_cnt};
						if (dec_cnt == '0) begin
							if (r_listed) begin
								res_status = ST_BAD_FREE;
							end else begin
								wr_entry  = {1'b1, empty_q, head_q, dec_cnt};
								head_d    = addr_s1;
								empty_d   = 1'b0;
								res_freed = 1'b1;
							end
						end
					end
				end
				default: ;
			endcase
		end
	end

	assign load_out  = busy_q && (!m_tvalid_q || m_tready);
	assign mem_we    = init_busy || (load_out && wr_en);
	assign mem_waddr = init_busy ? init_addr : addr_s1;
	assign mem_wdata = init_busy ? init_wdata : wr_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			empty_q    <= 1'b1;
			busy_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (init_busy) begin
				head_q  <= rb_head;
				empty_q <= rb_empty;
			end else if (load_out) begin
				head_q  <= head_d;
				empty_q <= empty_d;
			end
			if (accept) begin
				busy_q <= 1'b1;
			end else if (load_out) begin
				busy_q <= 1'b0;
			end
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_page_q   <= res_page;
			out_cnt_q    <= res_cnt;
			out_freed_q  <= res_freed;
			out_status_q <= res_status;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'b0, out_status_q, out_freed_q, out_cnt_q, out_page_q};

endmodule

>>> rtl/pfa_checker.sv
// ----------------------------------------------------------------------------
// pfa_checker
// Port-level checks for the page frame allocator, bound to the top level.
// ----------------------------------------------------------------------------
module pfa_checker import pfa_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata
);

	logic [2:0] st;
	assign st = m_tdata[34:32];

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result item dropped while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item accepted while one is in flight");

	a_freed_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[31] |-> st == ST_OK && m_tdata[30:15] == '0)
		else $error("freed page with nonzero count or error status");

	a_oom_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && st == ST_OOM |-> m_tdata[31:0] == '0)
		else $error("out of memory result carries data");

endmodule

bind page_frame_allocator_refcount pfa_checker u_pfa_checker (.*);

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the page frame allocator: a local model of the free
// list and the per-page counts predicts every result. A directed opening covers
// the special cases, and random alloc/free/inc/dec traffic runs under six
// register settings. Both stream sides idle at random, and the result side
// holds off for a long stretch once.
// ----------------------------------------------------------------------------
module tb_top;
	import pfa_pkg::*;

	localparam int FRAMES     = 32768;
	localparam int LOW_SPAN   = 1024;
	localparam int QUIET_MAX  = 150000;
	localparam int BACKLOG_LO = 8;

	typedef struct {
		op_t              op;
		logic [PAGE_W-1:0] page;
	} frame_req_t;

	typedef struct {
		logic [PAGE_W-1:0]  page_out;
		logic [COUNT_W-1:0] count;
		logic               freed;
		status_t            status;
	} frame_res_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic        cfg_index = REG_TOTAL;
	logic [15:0] cfg_wdata = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata   = '0;   // op[1:0], page[16:2]
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [39:0] m_tdata;          // page_out[14:0], count_after[30:15], freed[31],
	                               // status[34:32]

	// allocator model
	int unsigned        set_total;
	int unsigned        set_first;
	logic [COUNT_W-1:0] frame_cnt [FRAMES];
	logic [15:0]        frame_next [FRAMES];
	logic               on_list [FRAMES];
	logic [PAGE_W-1:0]  list_top;
	logic               list_none;

	frame_req_t op_backlog [$];
	frame_res_t pending_results [$];
	logic [PAGE_W-1:0] held_pages [$];
	frame_req_t on_bus;
	frame_res_t step_res;
	frame_res_t got_res;

	int burst_left;
	int gap_left;
	int hold_left;
	int mode;
	int mode_left;
	bit long_hold_done;
	int quiet;
	int errors;
	int queued_count;
	int sent_count;
	int checked_count;
	int settings_done;
	int status_seen [5];

	page_frame_allocator_refcount #(
		.NUM_PAGES  (FRAMES),
		.LOW_REGION (LOW_SPAN)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int unsigned live_total();
		return (set_total > FRAMES) ? FRAMES : set_total;
	endfunction

	function automatic int unsigned live_first();
		return (set_first > live_total()) ? live_total() : set_first;
	endfunction

	function automatic void push_frame(int unsigned p);
		frame_next[p] = list_none ? 16'h8000 : {1'b0, list_top};
		list_top      = p[PAGE_W-1:0];
		list_none     = 1'b0;
		on_list[p]    = 1'b1;
	endfunction

	function automatic void rebuild_frames();
		int unsigned lim;
		int unsigned first;
		int unsigned low_end;
		int unsigned hi_start;
		lim      = live_total();
		first    = live_first();
		low_end  = (LOW_SPAN > lim) ? lim : LOW_SPAN;
		hi_start = (first > LOW_SPAN) ? first : LOW_SPAN;
		list_top  = '0;
		list_none = 1'b1;
		for (int i = 0; i < FRAMES; i++) begin
			frame_next[i] = '0;
			on_list[i]    = 1'b0;
			frame_cnt[i]  = (i < first) ? 16'd1 : 16'd0;
		end
		for (int unsigned i = hi_start; i < lim; i++)
			push_frame(i);
		for (int unsigned i = first; i < low_end; i++)
			push_frame(i);
	endfunction

	function automatic frame_res_t frame_step(frame_req_t rq);
		frame_res_t r;
		logic [PAGE_W-1:0] p;
		r.page_out = rq.page;
		r.count    = '0;
		r.freed    = 1'b0;
		r.status   = ST_OK;
		if (rq.op == OP_ALLOC) begin
			if (list_none) begin
				r.page_out = '0;
				r.status   = ST_OOM;
			end else begin
				p = list_top;
				if (frame_next[p][15])
					list_none = 1'b1;
				else
					list_top = frame_next[p][PAGE_W-1:0];
				on_list[p]    = 1'b0;
				frame_next[p] = 16'h8000;
				r.page_out    = p;
				r.count       = frame_cnt[p];
			end
		end else if (rq.page >= live_total()) begin
			r.status = ST_RANGE;
		end else begin
			r.count = frame_cnt[rq.page];
			case (rq.op)
				OP_FREE: begin
					if (r.count != 0 || on_list[rq.page]) begin
						r.status = ST_BAD_FREE;
					end else begin
						push_frame(rq.page);
						r.freed = 1'b1;
					end
				end
				OP_INC: begin
					if (r.count == COUNT_MAX) begin
						r.status = ST_OVERFLOW;
					end else begin
						r.count = r.count + 1'b1;
						frame_cnt[rq.page] = r.count;
					end
				end
				default: begin
					if (r.count == 0) begin
						r.status = ST_BAD_FREE;
					end else begin
						r.count = r.count - 1'b1;
						frame_cnt[rq.page] = r.count;
						if (r.count == 0) begin
							if (on_list[rq.page]) begin
								r.status = ST_BAD_FREE;
							end else begin
								push_frame(rq.page);
								r.freed = 1'b1;
							end
						end
					end
				end
			endcase
		end
		return r;
	endfunction

	function automatic void track_held(frame_res_t r, op_t op);
		if (op == OP_ALLOC && r.status == ST_OK)
			held_pages.push_back(r.page_out);
		if (r.freed) begin
			foreach (held_pages[i]) begin
				if (held_pages[i] == r.page_out) begin
					held_pages.delete(i);
					break;
				end
			end
		end
	endfunction

	task automatic queue_req(op_t op, logic [PAGE_W-1:0] page);
		frame_req_t q;
		q.op   = op;
		q.page = page;
		op_backlog.push_back(q);
		queued_count++;
	endtask

	task automatic drain();
		do @(negedge clk);
		while (op_backlog.size() != 0 || s_tvalid || pending_results.size() != 0);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [15:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		do @(negedge clk);
		while (!s_tready);
	endtask

	task automatic apply_setting(logic [15:0] total, logic [15:0] first);
		drain();
		write_reg(REG_TOTAL, total);
		write_reg(REG_FIRST_FREE, first);
		set_total = 32'(total);
		set_first = 32'(first & 16'h07FF);
		rebuild_frames();
		held_pages.delete();
		settings_done++;
	endtask

	task automatic queue_directed();
		queue_req(OP_ALLOC, 15'h7FFF);
		queue_req(OP_FREE, 15'd1023);
		queue_req(OP_FREE, 15'd1023);
		queue_req(OP_ALLOC, 15'd0);
		queue_req(OP_INC, 15'd1023);
		queue_req(OP_FREE, 15'd1023);
		queue_req(OP_INC, 15'd1023);
		queue_req(OP_DEC, 15'd1023);
		queue_req(OP_DEC, 15'd1023);
		queue_req(OP_DEC, 15'd1023);
		queue_req(OP_INC, 15'd1022);
		queue_req(OP_DEC, 15'd1022);
		queue_req(OP_FREE, 15'd5);
		queue_req(OP_DEC, 15'd5);
		queue_req(OP_ALLOC, 15'd0);
		queue_req(OP_INC, 15'h7FFF);
		queue_req(OP_DEC, 15'h7FFF);
		queue_req(OP_FREE, 15'd0);
	endtask

	task automatic queue_edges();
		logic [PAGE_W-1:0] top;
		top = PAGE_W'(live_total() - 1);
		queue_req(OP_ALLOC, 15'h7FFF);
		queue_req(OP_INC, top);
		queue_req(OP_DEC, top);
		queue_req(OP_FREE, top);
		if (live_total() < FRAMES) begin
			queue_req(OP_FREE, top + 1'b1);
			queue_req(OP_INC, top + 1'b1);
			queue_req(OP_DEC, 15'h7FFF);
		end
		queue_req(OP_ALLOC, 15'd0);
	endtask

	task automatic queue_random(int n);
		int r;
		int unsigned lim;
		logic [PAGE_W-1:0] pg;
		op_t op;
		for (int k = 0; k < n; k++) begin
			while (op_backlog.size() >= BACKLOG_LO)
				@(negedge clk);
			r   = $urandom_range(0, 99);
			lim = live_total();
			if (held_pages.size() != 0)
				pg = held_pages[$urandom_range(0, held_pages.size() - 1)];
			if (r < 30 || (r < 75 && held_pages.size() == 0)) begin
				op = OP_ALLOC;
				pg = PAGE_W'($urandom_range(0, FRAMES - 1));
			end else if (r < 45) begin
				op = OP_INC;
			end else if (r < 62) begin
				op = OP_DEC;
			end else if (r < 75) begin
				op = OP_FREE;
			end else if (r < 85) begin
				op = op_t'($urandom_range(1, 3));
				pg = PAGE_W'($urandom_range(0, live_first() - 1));
			end else begin
				op = op_t'($urandom_range(0, 3));
				if ($urandom_range(0, 1))
					pg = PAGE_W'($urandom_range(0, FRAMES - 1));
				else if (lim + 1 >= FRAMES)
					pg = PAGE_W'($urandom_range(FRAMES - 3, FRAMES - 1));
				else
					pg = PAGE_W'($urandom_range(lim - 2, lim + 1));
			end
			queue_req(op, pg);
		end
	endtask

	// sender: bursts of items with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid   <= 1'b0;
			s_tdata    <= '0;
			burst_left = 4;
			gap_left   = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				sent_count++;
				step_res = frame_step(on_bus);
				pending_results.push_back(step_res);
				track_held(step_res, on_bus.op);
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (op_backlog.size() != 0) begin
					on_bus = op_backlog.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {7'd0, on_bus.page, on_bus.op};
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 24);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: check results, stall on a changing pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready       <= 1'b0;
			hold_left      = 0;
			mode           = 0;
			mode_left      = 0;
			long_hold_done = 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_res.page_out = m_tdata[14:0];
				got_res.count    = m_tdata[30:15];
				got_res.freed    = m_tdata[31];
				got_res.status   = status_t'(m_tdata[34:32]);
				if (got_res.status <= ST_OVERFLOW)
					status_seen[got_res.status]++;
				if (pending_results.size() == 0) begin
					$error("result with no item pending: page_out %0d status %0d",
						got_res.page_out, got_res.status);
					errors++;
				end else begin
					step_res = pending_results.pop_front();
					checked_count++;
					if (got_res.page_out !== step_res.page_out) begin
						$error("page_out: expected %0d, got %0d",
							step_res.page_out, got_res.page_out);
						errors++;
					end
					if (got_res.count !== step_res.count) begin
						$error("count_after: expected %0d, got %0d",
							step_res.count, got_res.count);
						errors++;
					end
					if (got_res.freed !== step_res.freed) begin
						$error("freed: expected %0d, got %0d",
							step_res.freed, got_res.freed);
						errors++;
					end
					if (got_res.status !== step_res.status) begin
						$error("status: expected %0d, got %0d",
							step_res.status, got_res.status);
						errors++;
					end
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (!long_hold_done && checked_count >= 40) begin
				long_hold_done = 1'b1;
				hold_left      = 400;
				m_tready       <= 1'b0;
			end else if ($urandom_range(0, 1999) == 0) begin
				hold_left = $urandom_range(30, 200);
				m_tready  <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode      = $urandom_range(0, 3);
					mode_left = $urandom_range(32, 400);
				end else begin
					mode_left--;
				end
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 3) != 0);
					2: m_tready <= ($urandom_range(0, 3) == 0);
					default: m_tready <= (mode_left % 3 != 0);
				endcase
			end
		end
	end

	// watchdog: covers the rebuild pass after reset and each register write
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_MAX) begin
				$display("page_frame_allocator_refcount test failed");
				$finish;
			end
		end
	end

	initial begin
		quiet         = 0;
		errors        = 0;
		queued_count  = 0;
		sent_count    = 0;
		checked_count = 0;
		settings_done = 1;
		foreach (status_seen[i])
			status_seen[i] = 0;
		set_total = 32768;
		set_first = 256;
		rebuild_frames();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		queue_directed();
		queue_edges();
		queue_random(200);

		apply_setting(16'd1500, 16'd300);
		queue_edges();
		queue_random(250);

		apply_setting(16'd1024, 16'd1024);
		queue_edges();
		queue_random(100);

		apply_setting(16'd600, 16'd2047);
		queue_edges();
		queue_random(100);

		apply_setting(16'hFFFF, 16'd1024);
		queue_edges();
		queue_random(150);

		apply_setting(16'd2000, 16'd700);
		queue_edges();
		queue_random(150);

		drain();
		repeat (8) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d results never arrived", pending_results.size());
			errors++;
		end
		$display("Ran %0d register settings: %0d items sent, %0d results checked, %0d errors.",
			settings_done, sent_count, checked_count, errors);
		$display("Results by status: ok %0d, out of memory %0d, bad free %0d,",
			status_seen[0], status_seen[1], status_seen[2]);
		$display("  range %0d, overflow %0d.", status_seen[3], status_seen[4]);
		if (errors == 0)
			$display("page_frame_allocator_refcount test passed");
		else
			$display("page_frame_allocator_refcount test failed");
		$finish;
	end

endmodule

>>> sim.f
rtl/pfa_pkg.sv
rtl/pfa_page_mem.sv
rtl/pfa_rebuild.sv
rtl/page_frame_allocator_refcount.sv
rtl/pfa_checker.sv
tb/sv/tb_top.sv
